[src/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CBS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define CBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[src/cbs_pkg.sv]
package cbs_pkg;

   // Scanner modes
   typedef enum logic [2:0] {
      MODE_OUTSIDE,
      MODE_SKIP,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_CSTAR,
      MODE_DQ,
      MODE_SQ,
      MODE_AFTER_SQ
   } scan_mode_type;

   // Byte classes found by the front end
   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_LBRACE,
      CLS_RBRACE,
      CLS_SLASH,
      CLS_STAR,
      CLS_SQUOTE,
      CLS_DQUOTE,
      CLS_NEWLINE
   } char_class_type;

   localparam logic [7:0] CH_LBRACE  = 8'd123;
   localparam logic [7:0] CH_RBRACE  = 8'd125;
   localparam logic [7:0] CH_SLASH   = 8'd47;
   localparam logic [7:0] CH_STAR    = 8'd42;
   localparam logic [7:0] CH_SQUOTE  = 8'd39;
   localparam logic [7:0] CH_DQUOTE  = 8'd34;
   localparam logic [7:0] CH_NEWLINE = 8'd10;

   localparam logic [7:0] NEWLINE_RUN_MAX   = 8'd255;
   localparam logic [7:0] MAX_NEWLINE_RESET = 8'd3;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   typedef struct packed {
      logic [7:0]     char_byte;
      char_class_type char_class;
      logic           last;
   } scan_item_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QUEUE_CW-1:0] count;
   } queue_status_type;

   typedef struct packed {
      scan_mode_type mode;
      logic          depth_zero;
   } scan_status_type;

endpackage

[src/c_brace_body_stripper_core.sv]
// An accepted req beat passes through the queue, then the output register, to become its rsp beat.
// Throughput: 1 byte per cycle while the queue has room; a 4-entry queue sits between classifier and scanner.
// The scanner takes one queued byte per cycle while the output register is free or drained.
// Reset (synchronous, active high): scanner outside braces, counters and overflow clear,
//   queue and output empty, newline run limit back to 3. No clearing pass.
`include "assert_macros.svh"

module c_brace_body_stripper_core
   import cbs_pkg::*;
#(
   parameter int MAX_DEPTH = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // end_of_file
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic [0:0] rsp_tuser    // [0] depth_overflow
);

   logic             push;
   logic             pop;
   scan_item_type    push_item;
   scan_item_type    head_item;
   queue_status_type q_stat;
   scan_status_type  scan_stat;

   // Classify and accept
   cbs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item)
   );

   // Decouple front and back
   cbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   // Scan and emit
   cbs_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head_item  (head_item),
      .q_stat     (q_stat),
      .pop        (pop),
      .scan_stat  (scan_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `CBS_ASSERT_SAME(a_no_pop_on_stall, clock, reset, rsp_tvalid && !rsp_tready, !pop)
   `CBS_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, q_stat.count <= QUEUE_CW'(QUEUE_DEPTH))
   `CBS_ASSERT_SAME(a_outside_depth0, clock, reset, scan_stat.mode == MODE_OUTSIDE,
      scan_stat.depth_zero)
   `CBS_ASSERT_NEXT(a_last_clears, clock, reset, pop && head_item.last,
      scan_stat.mode == MODE_OUTSIDE && scan_stat.depth_zero)

endmodule

[src/cbs_front.sv]
module cbs_front
   import cbs_pkg::*;
(
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] char_in
   input  logic             req_tlast,   // end_of_file
   input  queue_status_type q_stat,
   output logic             push,
   output scan_item_type    push_item
);

   char_class_type cls;

   // Classify the incoming byte
   always_comb begin
      case (req_tdata)
         CH_LBRACE:  cls = CLS_LBRACE;
         CH_RBRACE:  cls = CLS_RBRACE;
         CH_SLASH:   cls = CLS_SLASH;
         CH_STAR:    cls = CLS_STAR;
         CH_SQUOTE:  cls = CLS_SQUOTE;
         CH_DQUOTE:  cls = CLS_DQUOTE;
         CH_NEWLINE: cls = CLS_NEWLINE;
         default:    cls = CLS_OTHER;
      endcase
   end

   // Accept a beat whenever the queue has room
   assign req_tready           = !q_stat.full;
   assign push                 = req_tvalid && !q_stat.full;
   assign push_item.char_byte  = req_tdata;
   assign push_item.char_class = cls;
   assign push_item.last       = req_tlast;

endmodule

[src/cbs_queue.sv]
module cbs_queue
   import cbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  scan_item_type    push_item,
   input  logic             pop,
   output scan_item_type    head_item,
   output queue_status_type q_stat
);

   scan_item_type       slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.count = count_ff;

endmodule

[src/cbs_back.sv]
module cbs_back
   import cbs_pkg::*;
#(
   parameter int MAX_DEPTH = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata,
   input  scan_item_type    head_item,
   input  queue_status_type q_stat,
   output logic             pop,
   output scan_status_type  scan_stat,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] char_out
   output logic [0:0]       rsp_tuser    // [0] depth_overflow
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

   logic [7:0]         max_nl_ff;
   scan_mode_type      mode_ff, mode_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [7:0]         nl_run_ff, nl_run_in;
   logic               ovf_ff, ovf_in;
   logic               emit;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff;
   logic               rsp_ovf_ff;

   scan_mode_type      skip_mode;
   logic [DEPTH_W-1:0] skip_depth;
   logic               skip_ovf;
   logic [DEPTH_W-1:0] depth_dec;

   // Take the next beat when the output register frees up
   assign pop = !q_stat.empty && (!rsp_valid_ff || rsp_tready);

   // Plain skipped-byte handling inside a brace body
   always_comb begin
      depth_dec  = (depth_ff != '0) ? depth_ff - DEPTH_W'(1) : depth_ff;
      skip_mode  = MODE_SKIP;
      skip_depth = depth_ff;
      skip_ovf   = ovf_ff;
      case (head_item.char_class)
         CLS_RBRACE: begin
            skip_depth = depth_dec;
            skip_mode  = (depth_dec == '0) ? MODE_OUTSIDE : MODE_SKIP;
         end
         CLS_LBRACE: begin
            if (depth_ff >= DEPTH_W'(MAX_DEPTH)) begin
               skip_ovf = 1'b1;
            end else begin
               skip_depth = depth_ff + DEPTH_W'(1);
            end
         end
         CLS_SLASH:  skip_mode = MODE_SLASH;
         CLS_DQUOTE: skip_mode = MODE_DQ;
         CLS_SQUOTE: skip_mode = MODE_SQ;
         default:    skip_mode = MODE_SKIP;
      endcase
   end

   // Scanner next state
   always_comb begin
      mode_in   = mode_ff;
      depth_in  = depth_ff;
      nl_run_in = nl_run_ff;
      ovf_in    = ovf_ff;
      emit      = 1'b0;
      if (pop) begin
         case (mode_ff)
            MODE_OUTSIDE: begin
               if (head_item.char_class == CLS_LBRACE) begin
                  depth_in = DEPTH_W'(1);
                  mode_in  = MODE_SKIP;
               end else begin
                  if (head_item.char_class == CLS_NEWLINE) begin
                     nl_run_in = (nl_run_ff == NEWLINE_RUN_MAX) ?
                                 nl_run_ff : nl_run_ff + 8'd1;
                  end else begin
                     nl_run_in = '0;
                  end
                  emit = (nl_run_in <= max_nl_ff);
               end
            end
            MODE_SKIP: begin
               mode_in  = skip_mode;
               depth_in = skip_depth;
               ovf_in   = skip_ovf;
            end
            MODE_SLASH: begin
               mode_in = (head_item.char_class == CLS_STAR) ? MODE_COMMENT : MODE_SKIP;
            end
            MODE_COMMENT: begin
               if (head_item.char_class == CLS_STAR) begin
                  mode_in = MODE_CSTAR;
               end
            end
            MODE_CSTAR: begin
               mode_in = (head_item.char_class == CLS_SLASH) ? MODE_SKIP : MODE_COMMENT;
            end
            MODE_DQ: begin
               if (head_item.char_class == CLS_DQUOTE) begin
                  mode_in = MODE_SKIP;
               end
            end
            MODE_SQ: begin
               if (head_item.char_class == CLS_SQUOTE) begin
                  mode_in = MODE_AFTER_SQ;
               end
            end
            MODE_AFTER_SQ: begin
               if (head_item.char_class == CLS_SQUOTE) begin
                  mode_in = MODE_SKIP;
               end else begin
                  mode_in  = skip_mode;
                  depth_in = skip_depth;
                  ovf_in   = skip_ovf;
               end
            end
            default: mode_in = MODE_OUTSIDE;
         endcase
         // Drop all scan state after the last byte of a file
         if (head_item.last) begin
            mode_in   = MODE_OUTSIDE;
            depth_in  = '0;
            nl_run_in = '0;
            ovf_in    = 1'b0;
         end
      end
   end

   // Hold the result until taken
   assign rsp_valid_in = pop ? emit : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OUTSIDE;
         depth_ff     <= '0;
         nl_run_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_nl_ff    <= MAX_NEWLINE_RESET;
      end else begin
         mode_ff      <= mode_in;
         depth_ff     <= depth_in;
         nl_run_ff    <= nl_run_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_nl_ff <= csr_wdata;
         end
      end
   end

   // Load the output payload
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_char_ff <= head_item.char_byte;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid           = rsp_valid_ff;
   assign rsp_tdata            = rsp_char_ff;
   assign rsp_tuser            = rsp_ovf_ff;
   assign scan_stat.mode       = mode_ff;
   assign scan_stat.depth_zero = (depth_ff == '0);

endmodule
